FILE: src/wgit_pkg.sv
// ----------------------------------------------------------------------------
// wgit_pkg: shared definitions for the Winograd input tile transform
// Default sizes, configuration register map and reset values.
// ----------------------------------------------------------------------------
package wgit_pkg;

  // Default sizes of the design
  localparam int DEF_MAX_ROWS     = 32;
  localparam int DEF_MAX_COLS     = 32;
  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_ROWS     = 4'd0,
    REG_NUM_COLS     = 4'd1,
    REG_NUM_CHANNELS = 4'd2,
    REG_NUM_IMAGES   = 4'd3
  } reg_idx_e;

  // Register widths and reset values
  localparam int NUM_ROWS_W     = 6;
  localparam int NUM_COLS_W     = 6;
  localparam int NUM_CHANNELS_W = 7;
  localparam int NUM_IMAGES_W   = 16;

  localparam logic [NUM_ROWS_W-1:0]     RST_NUM_ROWS     = 6'd32;
  localparam logic [NUM_COLS_W-1:0]     RST_NUM_COLS     = 6'd32;
  localparam logic [NUM_CHANNELS_W-1:0] RST_NUM_CHANNELS = 7'd64;
  localparam logic [NUM_IMAGES_W-1:0]   RST_NUM_IMAGES   = 16'd1;

  // Result fields
  localparam int IMAGE_W     = 16;
  localparam int TILE_IDX_W  = 4;
  localparam int CHANNEL_W   = 6;
  localparam int COMP_W      = 4;
  localparam int TILE_ELEMS  = 16;

  localparam logic [COMP_W-1:0] COMP_LAST = 4'd15;

endpackage

FILE: src/winograd_input_tile_transform.sv
// ----------------------------------------------------------------------------
// winograd_input_tile_transform: F(2x2,3x3) input tile transform
// Streams samples in image, row, column, channel order, keeps the last four
// rows in a line store and emits B^T d B for each completed 4x4 tile.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  input     in_valid_i / in_ready_o, sample_i         in
//  result    out_valid_o / out_ready_i, image_index_o,  out
//            tile_row_o, tile_col_o, channel_o,
//            component_o, value_o, last_o
//  config    cfg_valid_i / cfg_ready_o, cfg_index_i,    in
//            cfg_data_i
//
// A sample that completes no tile does not hold off the next request. A
// sample that completes a tile holds off the next request through the
// request, the read state (15 reads of the line store through its single
// registered read port, one a cycle) and the wait state that loads the
// transform into the output buffer. The 16 results then drain from the
// output buffer, one per cycle while out_ready_i is high, as further
// requests enter. In a large image about one sample in four completes a tile.
// Reset clears control state and sets the configuration registers to their
// reset values; the line store is not cleared, since every tile reads only
// entries written earlier in the same image. A stalled result holds the output
// buffer; a finished tile then waits for it and holds off new requests meanwhile.

module winograd_input_tile_transform #(
  parameter int MAX_ROWS     = wgit_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS     = wgit_pkg::DEF_MAX_COLS,
  parameter int MAX_CHANNELS = wgit_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_WIDTH = wgit_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wgit_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [wgit_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input samples
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [wgit_pkg::IMAGE_W-1:0]          image_index_o,
  output logic [wgit_pkg::TILE_IDX_W-1:0]       tile_row_o,
  output logic [wgit_pkg::TILE_IDX_W-1:0]       tile_col_o,
  output logic [wgit_pkg::CHANNEL_W-1:0]        channel_o,
  output logic [wgit_pkg::COMP_W-1:0]           component_o,
  output logic signed [SAMPLE_WIDTH+1:0]        value_o,
  output logic                                  last_o
);

  localparam int SW          = SAMPLE_WIDTH;
  localparam int TW          = SAMPLE_WIDTH + 1;
  localparam int VW          = SAMPLE_WIDTH + 2;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROWS_CW     = $clog2(MAX_ROWS + 1);
  localparam int COLS_CW     = $clog2(MAX_COLS + 1);
  localparam int CHS_CW      = $clog2(MAX_CHANNELS + 1);
  localparam int ROW_STRIDE  = MAX_COLS * MAX_CHANNELS;
  localparam int STORE_DEPTH = 4 * ROW_STRIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int NREAD       = wgit_pkg::TILE_ELEMS - 1;
  localparam int IMG_W       = wgit_pkg::IMAGE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } state_e;

  // Configuration and stream position registers
  logic [wgit_pkg::NUM_ROWS_W-1:0]     num_rows_q;
  logic [wgit_pkg::NUM_COLS_W-1:0]     num_cols_q;
  logic [wgit_pkg::NUM_CHANNELS_W-1:0] num_channels_q;
  logic [wgit_pkg::NUM_IMAGES_W-1:0]   num_images_q;
  logic [ROW_W-1:0]                    row_q;
  logic [COL_W-1:0]                    col_q;
  logic [CH_W-1:0]                     ch_q;
  logic [IMG_W-1:0]                    img_q;

  // Sequencer
  state_e                              state_q;
  logic [3:0]                          rd_cnt_q;
  logic                                out_busy_q;
  logic [wgit_pkg::COMP_W-1:0]         out_cnt_q;

  // Line store and tile gather
  logic signed [SW-1:0]                store_mem [STORE_DEPTH];
  logic signed [SW-1:0]                rd_q;
  logic signed [SW-1:0]                gather_q [NREAD];
  logic signed [SW-1:0]                samp_q;
  logic [1:0]                          t_slot_q;
  logic [COL_W-1:0]                    t_col_q;
  logic [CH_W-1:0]                     t_ch_q;
  logic [IMG_W-1:0]                    t_img_q;
  logic [wgit_pkg::TILE_IDX_W-1:0]     t_tr_q;
  logic [wgit_pkg::TILE_IDX_W-1:0]     t_tc_q;

  // Output buffer
  logic signed [VW-1:0]                obuf_q [wgit_pkg::TILE_ELEMS];
  logic [IMG_W-1:0]                    o_img_q;
  logic [wgit_pkg::TILE_IDX_W-1:0]     o_tr_q;
  logic [wgit_pkg::TILE_IDX_W-1:0]     o_tc_q;
  logic [CH_W-1:0]                     o_ch_q;

  // Combinational
  logic [ROWS_CW-1:0]                  rows_eff;
  logic [COLS_CW-1:0]                  cols_eff;
  logic [CHS_CW-1:0]                   chans_eff;
  logic [IMG_W-1:0]                    imgs_eff;
  logic                                cfg_acc, cfg_hit, in_acc, out_acc;
  logic                                tile_hit, obuf_free, load, rd_en, shift_en;
  logic                                ch_wrap, col_wrap, row_wrap, img_wrap;
  logic [ROW_W-1:0]                    row_d;
  logic [COL_W-1:0]                    col_d;
  logic [CH_W-1:0]                     ch_d;
  logic [IMG_W-1:0]                    img_d;
  logic [ADDR_W-1:0]                   wr_addr, rd_addr;
  logic [1:0]                          rd_slot;
  logic [COL_W-1:0]                    rd_col;
  logic signed [SW-1:0]                d_tile [wgit_pkg::TILE_ELEMS];
  logic signed [TW-1:0]                t_tile [wgit_pkg::TILE_ELEMS];
  logic signed [VW-1:0]                o_tile [wgit_pkg::TILE_ELEMS];

  // Flat line store address of (row slot, column, channel)
  function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0]       slot,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [CH_W-1:0]  ch);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(slot) * ADDR_W'(ROW_STRIDE) + ADDR_W'(col) * ADDR_W'(MAX_CHANNELS)
        + ADDR_W'(ch);
    return a;
  endfunction

  // Clamp the configured sizes
  always_comb begin
    if (num_rows_q == '0) begin
      rows_eff = ROWS_CW'(1);
    end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
      rows_eff = ROWS_CW'(MAX_ROWS);
    end else begin
      rows_eff = ROWS_CW'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      cols_eff = COLS_CW'(1);
    end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
      cols_eff = COLS_CW'(MAX_COLS);
    end else begin
      cols_eff = COLS_CW'(num_cols_q);
    end
    if (num_channels_q == '0) begin
      chans_eff = CHS_CW'(1);
    end else if (32'(num_channels_q) > 32'(MAX_CHANNELS)) begin
      chans_eff = CHS_CW'(MAX_CHANNELS);
    end else begin
      chans_eff = CHS_CW'(num_channels_q);
    end
    imgs_eff = (num_images_q == '0) ? IMG_W'(1) : num_images_q;
  end

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_acc && (32'(cfg_index_i) <= 32'(wgit_pkg::REG_NUM_IMAGES));
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_busy_q;
  assign out_acc     = out_valid_o && out_ready_i;
  assign obuf_free   = !out_busy_q || (out_acc && last_o);
  assign load        = (state_q == ST_WAIT) && obuf_free;

  // Tile completes on odd row and column, both at least three
  assign tile_hit = row_q[0] && col_q[0] && (32'(row_q) >= 32'd3) && (32'(col_q) >= 32'd3)
                    && (32'(row_q >> 1) < 32'(rows_eff >> 1))
                    && (32'(col_q >> 1) < 32'(cols_eff >> 1));

  // Advance the stream position
  always_comb begin
    ch_wrap  = (32'(ch_q) + 32'd1) >= 32'(chans_eff);
    col_wrap = (32'(col_q) + 32'd1) >= 32'(cols_eff);
    row_wrap = (32'(row_q) + 32'd1) >= 32'(rows_eff);
    img_wrap = (32'(img_q) + 32'd1) >= 32'(imgs_eff);
    ch_d  = ch_q;
    col_d = col_q;
    row_d = row_q;
    img_d = img_q;
    if (ch_wrap) begin
      ch_d = '0;
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d = '0;
          img_d = img_wrap ? '0 : img_q + 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else begin
      ch_d = ch_q + 1'b1;
    end
  end

  // Store addresses: write at the incoming sample, read the tile in 4*i+j order
  assign wr_addr  = store_addr(row_q[1:0], col_q, ch_q);
  assign rd_slot  = t_slot_q + 2'd1 + rd_cnt_q[3:2];
  assign rd_col   = t_col_q - COL_W'(3) + COL_W'(rd_cnt_q[1:0]);
  assign rd_addr  = store_addr(rd_slot, rd_col, t_ch_q);
  assign rd_en    = (state_q == ST_READ) && (32'(rd_cnt_q) < 32'(NREAD));
  assign shift_en = (state_q == ST_READ) && (rd_cnt_q != '0);

  // Transform: column step down the rows, then row step along the columns
  always_comb begin
    for (int k = 0; k < NREAD; k++) begin
      d_tile[k] = gather_q[k];
    end
    d_tile[NREAD] = samp_q;
    for (int j = 0; j < 4; j++) begin
      t_tile[j]      = TW'(d_tile[j])     - TW'(d_tile[8 + j]);
      t_tile[4 + j]  = TW'(d_tile[4 + j]) + TW'(d_tile[8 + j]);
      t_tile[8 + j]  = TW'(d_tile[8 + j]) - TW'(d_tile[4 + j]);
      t_tile[12 + j] = TW'(d_tile[4 + j]) - TW'(d_tile[12 + j]);
    end
    for (int i = 0; i < 4; i++) begin
      o_tile[4*i]     = VW'(t_tile[4*i])     - VW'(t_tile[4*i + 2]);
      o_tile[4*i + 1] = VW'(t_tile[4*i + 1]) + VW'(t_tile[4*i + 2]);
      o_tile[4*i + 2] = VW'(t_tile[4*i + 2]) - VW'(t_tile[4*i + 1]);
      o_tile[4*i + 3] = VW'(t_tile[4*i + 1]) - VW'(t_tile[4*i + 3]);
    end
  end

  // Control: configuration, position, sequencer and output buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q     <= wgit_pkg::RST_NUM_ROWS;
      num_cols_q     <= wgit_pkg::RST_NUM_COLS;
      num_channels_q <= wgit_pkg::RST_NUM_CHANNELS;
      num_images_q   <= wgit_pkg::RST_NUM_IMAGES;
      row_q          <= '0;
      col_q          <= '0;
      ch_q           <= '0;
      img_q          <= '0;
      state_q        <= ST_IDLE;
      rd_cnt_q       <= '0;
      out_busy_q     <= 1'b0;
      out_cnt_q      <= '0;
    end else begin
      // register writes restart the stream
      if (cfg_acc) begin
        unique case (cfg_index_i)
          wgit_pkg::REG_NUM_ROWS:     num_rows_q     <= cfg_data_i[wgit_pkg::NUM_ROWS_W-1:0];
          wgit_pkg::REG_NUM_COLS:     num_cols_q     <= cfg_data_i[wgit_pkg::NUM_COLS_W-1:0];
          wgit_pkg::REG_NUM_CHANNELS: num_channels_q <=
                                        cfg_data_i[wgit_pkg::NUM_CHANNELS_W-1:0];
          wgit_pkg::REG_NUM_IMAGES:   num_images_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        row_q <= '0;
        col_q <= '0;
        ch_q  <= '0;
        img_q <= '0;
      end else if (in_acc) begin
        row_q <= row_d;
        col_q <= col_d;
        ch_q  <= ch_d;
        img_q <= img_d;
      end

      // sequence the tile reads
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && tile_hit) begin
            state_q  <= ST_READ;
            rd_cnt_q <= '0;
          end
        end
        ST_READ: begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (32'(rd_cnt_q) == 32'(NREAD)) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // drain the output buffer
      if (load) begin
        out_busy_q <= 1'b1;
        out_cnt_q  <= '0;
      end else if (out_acc) begin
        out_cnt_q <= out_cnt_q + 1'b1;
        if (last_o) begin
          out_busy_q <= 1'b0;
        end
      end
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      store_mem[wr_addr] <= sample_i;
    end
    if (rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  // Datapath: gather tile, latch tile position, load and shift the output buffer
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int k = 0; k < NREAD - 1; k++) begin
        gather_q[k] <= gather_q[k + 1];
      end
      gather_q[NREAD - 1] <= rd_q;
    end
    if (in_acc && tile_hit) begin
      samp_q   <= sample_i;
      t_slot_q <= row_q[1:0];
      t_col_q  <= col_q;
      t_ch_q   <= ch_q;
      t_img_q  <= img_q;
      t_tr_q   <= wgit_pkg::TILE_IDX_W'((row_q >> 1) - ROW_W'(1));
      t_tc_q   <= wgit_pkg::TILE_IDX_W'((col_q >> 1) - COL_W'(1));
    end
    if (load) begin
      for (int k = 0; k < wgit_pkg::TILE_ELEMS; k++) begin
        obuf_q[k] <= o_tile[k];
      end
      o_img_q <= t_img_q;
      o_tr_q  <= t_tr_q;
      o_tc_q  <= t_tc_q;
      o_ch_q  <= t_ch_q;
    end else if (out_acc) begin
      for (int k = 0; k < wgit_pkg::TILE_ELEMS - 1; k++) begin
        obuf_q[k] <= obuf_q[k + 1];
      end
    end
  end

  // Result fields
  assign value_o       = obuf_q[0];
  assign component_o   = out_cnt_q;
  assign last_o        = (out_cnt_q == wgit_pkg::COMP_LAST);
  assign image_index_o = o_img_q;
  assign tile_row_o    = o_tr_q;
  assign tile_col_o    = o_tc_q;
  assign channel_o     = wgit_pkg::CHANNEL_W'(o_ch_q);

  // A tile request starts the gather
  a_tile_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && tile_hit) |=> (state_q == ST_READ && rd_cnt_q == '0))
    else $error("tile request did not start the store read sequence");

  // A tile never drops out before its last element
  a_no_lost_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_o) |=> out_valid_o)
    else $error("result stream ended before the last element");

  // Elements leave in component order
  a_component_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_o) |=> (component_o == wgit_pkg::COMP_W'($past(component_o) + 1'b1)))
    else $error("result component out of order");

  // A fresh tile starts at component zero
  a_tile_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(load) |-> (out_valid_o && component_o == '0))
    else $error("tile load did not restart the component count");

endmodule

FILE: dv/tb_winograd_input_tile_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_winograd_input_tile_transform: stream test of the F(2x2,3x3) input tile
// Streams samples through the block under a set of image geometries, predicts
// every transformed tile element in a local line store model and checks each
// result in order, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_winograd_input_tile_transform;

  localparam int SW      = wgit_pkg::DEF_SAMPLE_WIDTH;
  localparam int VW      = SW + 2;
  localparam int MROWS   = wgit_pkg::DEF_MAX_ROWS;
  localparam int MCOLS   = wgit_pkg::DEF_MAX_COLS;
  localparam int MCHANS  = wgit_pkg::DEF_MAX_CHANNELS;
  localparam int LINE_DEPTH = 4 * MCOLS * MCHANS;
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int SETTLE  = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 40;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    logic [wgit_pkg::IMAGE_W-1:0]    image;
    logic [wgit_pkg::TILE_IDX_W-1:0] tile_row;
    logic [wgit_pkg::TILE_IDX_W-1:0] tile_col;
    logic [wgit_pkg::CHANNEL_W-1:0]  channel;
    logic [wgit_pkg::COMP_W-1:0]     component;
    logic [VW-1:0]                   value;
    logic                            last;
  } tile_elem_t;

  // Block ports
  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [wgit_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [wgit_pkg::CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic signed [SW-1:0]             sample_i    = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [wgit_pkg::IMAGE_W-1:0]     image_index_o;
  logic [wgit_pkg::TILE_IDX_W-1:0]  tile_row_o;
  logic [wgit_pkg::TILE_IDX_W-1:0]  tile_col_o;
  logic [wgit_pkg::CHANNEL_W-1:0]   channel_o;
  logic [wgit_pkg::COMP_W-1:0]      component_o;
  logic signed [VW-1:0]             value_o;
  logic                             last_o;

  // Stimulus and prediction state
  logic signed [SW-1:0] sample_q[$];
  tile_elem_t           tile_elems_q[$];
  tile_elem_t           got_elem;
  int unsigned          mismatches = 0;

  logic [wgit_pkg::NUM_ROWS_W-1:0]     geo_rows   = wgit_pkg::RST_NUM_ROWS;
  logic [wgit_pkg::NUM_COLS_W-1:0]     geo_cols   = wgit_pkg::RST_NUM_COLS;
  logic [wgit_pkg::NUM_CHANNELS_W-1:0] geo_chans  = wgit_pkg::RST_NUM_CHANNELS;
  logic [wgit_pkg::NUM_IMAGES_W-1:0]   geo_images = wgit_pkg::RST_NUM_IMAGES;
  int unsigned row_at = 0, col_at = 0, chan_at = 0, image_at = 0;
  logic signed [SW-1:0] line_mem [0:LINE_DEPTH-1];

  // Handshake bookkeeping between the edge processes
  bit                   in_taken  = 1'b0;
  bit                   out_taken = 1'b0;
  bit                   tx_busy   = 1'b0;
  bit                   tx_burst  = 1'b0;
  int unsigned          tx_wait   = 0;
  logic signed [SW-1:0] tx_sample = '0;
  bit                   rx_burst  = 1'b0;
  int unsigned          rx_wait   = 0;
  bit                   rx_hold   = 1'b0;
  bit                   hold_armed = 1'b0;
  int unsigned          hold_left = 0;

  winograd_input_tile_transform DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_i,
    .out_valid_o, .out_ready_i, .image_index_o, .tile_row_o, .tile_col_o,
    .channel_o, .component_o, .value_o, .last_o
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  // Store one sample, emit the transformed tile it completes, advance position
  task automatic transform_sample(input logic signed [SW-1:0] s);
    int unsigned rows, cols, chans, imgs, nr, nc, r, c, ch, tr, tc;
    int d[4][4];
    int t[4][4];
    int o[4];
    tile_elem_t e;
    rows  = clamp_dim(32'(geo_rows), MROWS);
    cols  = clamp_dim(32'(geo_cols), MCOLS);
    chans = clamp_dim(32'(geo_chans), MCHANS);
    imgs  = (geo_images == '0) ? 1 : 32'(geo_images);
    nr    = (rows >= 2) ? (rows - 2) / 2 : 0;
    nc    = (cols >= 2) ? (cols - 2) / 2 : 0;
    r = row_at; c = col_at; ch = chan_at;
    if (r >= rows) r = rows - 1;
    if (c >= cols) c = cols - 1;
    if (ch >= chans) ch = chans - 1;
    line_mem[LINE_AW'(((r % 4) * MCOLS + c) * MCHANS + ch)] = s;

    if ((r % 2 == 1) && (c % 2 == 1) && r >= 3 && c >= 3 &&
        (r - 3) / 2 < nr && (c - 3) / 2 < nc) begin
      tr = (r - 3) / 2;
      tc = (c - 3) / 2;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          d[i][j] = line_mem[LINE_AW'((((2 * tr + i) % 4) * MCOLS + 2 * tc + j) * MCHANS
                                      + ch)];
      // Transform down the rows, then along the columns
      for (int j = 0; j < 4; j++) begin
        t[0][j] = d[0][j] - d[2][j];
        t[1][j] = d[1][j] + d[2][j];
        t[2][j] = d[2][j] - d[1][j];
        t[3][j] = d[1][j] - d[3][j];
      end
      for (int i = 0; i < 4; i++) begin
        o[0] = t[i][0] - t[i][2];
        o[1] = t[i][1] + t[i][2];
        o[2] = t[i][2] - t[i][1];
        o[3] = t[i][1] - t[i][3];
        for (int j = 0; j < 4; j++) begin
          e.image     = image_at[wgit_pkg::IMAGE_W-1:0];
          e.tile_row  = tr[wgit_pkg::TILE_IDX_W-1:0];
          e.tile_col  = tc[wgit_pkg::TILE_IDX_W-1:0];
          e.channel   = ch[wgit_pkg::CHANNEL_W-1:0];
          e.component = wgit_pkg::COMP_W'(4 * i + j);
          e.value     = o[j][VW-1:0];
          e.last      = (4 * i + j == 32'(wgit_pkg::COMP_LAST));
          tile_elems_q.push_back(e);
        end
      end
    end

    ch++;
    if (ch >= chans) begin
      ch = 0;
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
        if (r >= rows) begin
          r = 0;
          image_at++;
          if (image_at >= imgs) image_at = 0;
        end
      end
    end
    row_at = r; col_at = c; chan_at = ch;
  endtask

  // Monitor: predict on accepted samples, check accepted results in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        transform_sample(sample_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        out_taken = 1'b1;
        if (tile_elems_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: img %0d row %0d col %0d ch %0d comp %0d val %0d",
                     image_index_o, tile_row_o, tile_col_o, channel_o, component_o,
                     value_o);
        end else begin
          got_elem = tile_elems_q.pop_front();
          if (image_index_o !== got_elem.image || tile_row_o !== got_elem.tile_row ||
              tile_col_o !== got_elem.tile_col || channel_o !== got_elem.channel ||
              component_o !== got_elem.component || value_o !== got_elem.value ||
              last_o !== got_elem.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp img %0d row %0d col %0d ch %0d comp %0d val %0d last %0b",
                       got_elem.image, got_elem.tile_row, got_elem.tile_col,
                       got_elem.channel, got_elem.component, $signed(got_elem.value),
                       got_elem.last);
            if (mismatches <= 10)
              $display("          got img %0d row %0d col %0d ch %0d comp %0d val %0d last %0b",
                       image_index_o, tile_row_o, tile_col_o, channel_o, component_o,
                       value_o, last_o);
          end
        end
      end
    end
  end

  // Long output hold-off once armed, counted in cycles
  always @(posedge clk_i) begin
    if (hold_armed && out_valid_o) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
      rx_hold    = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) rx_hold = 1'b0;
    end
  end

  // Driver: offer queued samples with a random gap after each request
  always @(negedge clk_i) begin
    if (in_taken) begin
      in_taken = 1'b0;
      tx_busy  = 1'b0;
      if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
      tx_wait = tx_burst ? 0 : $urandom_range(0, 14);
    end
    if (!tx_busy) begin
      if (tx_wait > 0) begin
        tx_wait--;
      end else if (sample_q.size() > 0) begin
        tx_sample = sample_q.pop_front();
        tx_busy   = 1'b1;
      end
    end
    in_valid_i <= tx_busy;
    sample_i   <= tx_sample;
  end

  // Receiver: drop ready for a random stall after each result
  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_ready_i <= (rx_wait == 0) && !rx_hold && rst_ni;
  end

  // Hold until every queued sample is taken and every result has come back
  task automatic wait_drained();
    @(posedge clk_i);
    while (sample_q.size() != 0 || tx_busy || tile_elems_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wgit_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [wgit_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      wgit_pkg::REG_NUM_ROWS:     geo_rows   = data[wgit_pkg::NUM_ROWS_W-1:0];
      wgit_pkg::REG_NUM_COLS:     geo_cols   = data[wgit_pkg::NUM_COLS_W-1:0];
      wgit_pkg::REG_NUM_CHANNELS: geo_chans  = data[wgit_pkg::NUM_CHANNELS_W-1:0];
      wgit_pkg::REG_NUM_IMAGES:   geo_images = data[wgit_pkg::NUM_IMAGES_W-1:0];
      default: ;
    endcase
    // Any valid register write restarts the stream
    if (32'(idx) <= 32'(wgit_pkg::REG_NUM_IMAGES)) begin
      row_at = 0; col_at = 0; chan_at = 0; image_at = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Set a geometry with random unused data bits, then queue random samples
  task automatic stream_phase(input int unsigned rows, input int unsigned cols,
                              input int unsigned chans, input int unsigned imgs,
                              input int unsigned n);
    logic [wgit_pkg::CFG_DATA_W-1:0] data;
    wait_drained();
    data = wgit_pkg::CFG_DATA_W'($urandom);
    data[wgit_pkg::NUM_ROWS_W-1:0] = wgit_pkg::NUM_ROWS_W'(rows);
    write_reg(wgit_pkg::REG_NUM_ROWS, data);
    data = wgit_pkg::CFG_DATA_W'($urandom);
    data[wgit_pkg::NUM_COLS_W-1:0] = wgit_pkg::NUM_COLS_W'(cols);
    write_reg(wgit_pkg::REG_NUM_COLS, data);
    data = wgit_pkg::CFG_DATA_W'($urandom);
    data[wgit_pkg::NUM_CHANNELS_W-1:0] = wgit_pkg::NUM_CHANNELS_W'(chans);
    write_reg(wgit_pkg::REG_NUM_CHANNELS, data);
    write_reg(wgit_pkg::REG_NUM_IMAGES, wgit_pkg::CFG_DATA_W'(imgs));
    repeat (n) sample_q.push_back(rand_sample());
  endtask

  initial begin
    int unsigned rand_total;
    int unsigned rows, cols, chans, imgs, n;
    rand_total = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: far too large for a tile in a few samples
    sample_q.push_back(S_MAX);
    sample_q.push_back(S_MIN);
    sample_q.push_back('0);
    sample_q.push_back('1);

    // Smallest image with a checkerboard of extreme samples
    stream_phase(4, 4, 1, 2, 0);
    for (int i = 0; i < 16; i++)
      sample_q.push_back(((i / 4 + i % 4) % 2 == 1) ? S_MAX : S_MIN);

    // Batch extremes: largest count, and zero acting as one
    stream_phase(4, 4, 1, 16'hFFFF, 32);
    stream_phase(4, 4, 1, 0, 32);

    // Odd sizes, sizes too small for a tile, and clamped sizes
    stream_phase(5, 7, 1, 2, 35);
    stream_phase(3, 8, 1, 1, 8);
    stream_phase(8, 0, 2, 1, 6);
    stream_phase(63, 5, 127, 1, 12);

    // Widest image, with the receiver stalled long enough to back up the input
    hold_armed = 1'b1;
    stream_phase(4, MCOLS, 1, 1, 4 * MCOLS);

    // Random geometries, mostly well formed whole images
    while (rand_total < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(5, 30);
          n = (n < RAND_ITEMS - rand_total) ? n : RAND_ITEMS - rand_total;
          stream_phase($urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 127), $urandom, n);
        end
        1: begin
          // Unmapped index: the stream carries on where it stood
          n = $urandom_range(10, 40);
          n = (n < RAND_ITEMS - rand_total) ? n : RAND_ITEMS - rand_total;
          wait_drained();
          write_reg(wgit_pkg::CFG_INDEX_W'($urandom_range(32'(wgit_pkg::REG_NUM_IMAGES) + 1,
                                                          2**wgit_pkg::CFG_INDEX_W - 1)),
                    wgit_pkg::CFG_DATA_W'($urandom));
          repeat (n) sample_q.push_back(rand_sample());
        end
        default: begin
          rows  = $urandom_range(4, 8);
          cols  = $urandom_range(4, 8);
          chans = $urandom_range(1, 2);
          case ($urandom_range(0, 7))
            0: imgs = 0;
            1: imgs = $urandom_range(1, 16'hFFFF);
            default: imgs = $urandom_range(1, 3);
          endcase
          n = rows * cols * chans * ((chans == 1) ? $urandom_range(1, 2) : 1);
          if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
          n = (n < RAND_ITEMS - rand_total) ? n : RAND_ITEMS - rand_total;
          stream_phase(rows, cols, chans, imgs, n);
        end
      endcase
      rand_total += n;
    end

    // Drain, allow stray results to show, then judge
    @(posedge clk_i);
    while (sample_q.size() != 0 || tx_busy) @(posedge clk_i);
    for (int k = 0; k < 20000 && tile_elems_q.size() != 0; k++) @(posedge clk_i);
    repeat (2 * SETTLE) @(posedge clk_i);
    mismatches += tile_elems_q.size();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
